>>> hw/rtl/tlsw_pkg.sv
// Package for the text line screen writer: screen geometry, field widths,
// character codes and the command type passed from the front to the back end.
// No dependencies.
package tlsw_pkg;

  localparam int SCREEN_ROWS = 24;
  localparam int SCREEN_COLS = 40;

  localparam int ADDR_W = 14;
  localparam int DATA_W = 8;
  localparam int COL_W  = $clog2(SCREEN_COLS + 1);
  localparam int IDX_W  = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
  localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

  localparam logic [COL_W-1:0]  COLS_COUNT = COL_W'(SCREEN_COLS);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLS);

  localparam logic [DATA_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [DATA_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ADDR_W-1:0] BASE_RESET   = 14'd6144;

  localparam logic KIND_END = 1'b1;

  localparam logic [1:0] CMD_CHAR    = 2'd0;
  localparam logic [1:0] CMD_NEWLINE = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] code;
  } cmd_t;

endpackage

>>> hw/rtl/tlsw_if.sv
// Channel interfaces of the text line screen writer: input items, video
// memory writes and the configuration write channel. Depends on tlsw_pkg.
interface tlsw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [tlsw_pkg::DATA_W-1:0] char_code;
  modport source(output valid, kind, char_code, input ready);
  modport sink(input valid, kind, char_code, output ready);
endinterface

interface tlsw_out_if;
  logic                      valid;
  logic                      ready;
  logic [tlsw_pkg::ADDR_W-1:0] vram_address;
  logic [tlsw_pkg::DATA_W-1:0] vram_data;
  logic                      last_of_row;
  modport source(output valid, vram_address, vram_data, last_of_row, input ready);
  modport sink(input valid, vram_address, vram_data, last_of_row, output ready);
endinterface

interface tlsw_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tlsw_pkg::ADDR_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> hw/rtl/tlsw_front.sv
// Front end: accepts input transactions, classifies them into commands and
// holds them in a two-entry queue for the back end. Depends on tlsw_pkg, tlsw_if.
module tlsw_front (
  input  logic           clk,
  input  logic           rst_n,
  tlsw_in_if.sink        in_chan,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output tlsw_pkg::cmd_t cmd
);
  import tlsw_pkg::*;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  cmd_t       q_r [2];
  logic       head_r, head_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop, tail;
  cmd_t       new_cmd;

  always_comb begin
    new_cmd.code = in_chan.char_code;
    if (in_chan.kind == KIND_END) begin
      new_cmd.op = CMD_END;
    end else if (in_chan.char_code == NEWLINE_CODE) begin
      new_cmd.op = CMD_NEWLINE;
    end else begin
      new_cmd.op = CMD_CHAR;
    end
  end

  assign in_chan.ready = (count_r != QUEUE_DEPTH);
  assign push          = in_chan.valid && in_chan.ready;
  assign cmd_valid     = (count_r != 2'd0);
  assign cmd           = q_r[head_r];
  assign pop           = cmd_valid && cmd_ready;
  assign tail          = head_r ^ count_r[0];

  always_comb begin
    head_nxt  = pop ? ~head_r : head_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail] <= new_cmd;
    end
  end

endmodule

>>> hw/rtl/tlsw_back.sv
// Back end: keeps the line buffer, column and row, carries out commands and
// drains a row through a read stage and an output register. Depends on tlsw_pkg, tlsw_if.
module tlsw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  tlsw_pkg::cmd_t cmd,
  tlsw_cfg_if.sink       cfg_chan,
  tlsw_out_if.source     out_chan
);
  import tlsw_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic [DATA_W-1:0] line_mem [SCREEN_COLS];
  logic [SCREEN_COLS-1:0] filled_r, filled_nxt;

  logic              state_r, state_nxt;
  logic              newline_r, newline_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] row_addr_r, row_addr_nxt;
  logic [ADDR_W-1:0] base_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_filled_r;
  logic              s1_last_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] rd_data_r;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;

  logic             out_free, s1_free, s1_move;
  logic             mem_we, issue, clear_row;
  logic [IDX_W-1:0] col_idx;

  assign col_idx   = col_r[IDX_W-1:0];
  assign cmd_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign s1_free   = !s1_valid_r || out_free;
  assign s1_move   = s1_valid_r && out_free;

  always_comb begin
    state_nxt    = state_r;
    newline_nxt  = newline_r;
    idx_nxt      = idx_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_addr_nxt = row_addr_r;
    mem_we       = 1'b0;
    issue        = 1'b0;
    clear_row    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            CMD_CHAR: begin
              // Characters past the last column are dropped.
              if (col_r < COLS_COUNT) begin
                mem_we  = 1'b1;
                col_nxt = col_r + COL_W'(1);
              end
            end
            CMD_NEWLINE: begin
              state_nxt   = ST_DRAIN;
              newline_nxt = 1'b1;
              idx_nxt     = '0;
            end
            CMD_END: begin
              if (col_r != '0) begin
                state_nxt   = ST_DRAIN;
                newline_nxt = 1'b0;
                idx_nxt     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (s1_free) begin
          issue = 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
            // The last read is issued at this edge, so the row may be cleared now.
            if (newline_r) begin
              clear_row = 1'b1;
              col_nxt   = '0;
              if (row_r == LAST_ROW) begin
                row_nxt      = '0;
                row_addr_nxt = '0;
              end else begin
                row_nxt      = row_r + ROW_W'(1);
                row_addr_nxt = row_addr_r + ROW_STRIDE;
              end
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    filled_nxt = filled_r;
    if (clear_row) begin
      filled_nxt = '0;
    end else if (mem_we) begin
      filled_nxt[col_idx] = 1'b1;
    end
  end

  always_comb begin
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      newline_r   <= 1'b0;
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      row_addr_r  <= '0;
      filled_r    <= '0;
      base_r      <= BASE_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newline_r   <= newline_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      row_addr_r  <= row_addr_nxt;
      filled_r    <= filled_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) begin
        base_r <= cfg_chan.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col_idx] <= cmd.code;
    end
    if (issue) begin
      rd_data_r <= line_mem[idx_r];
    end
  end

  // Read stage: cells never written since the last clear read as spaces.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_filled_r <= filled_r[idx_r];
      s1_last_r   <= (idx_r == LAST_IDX);
      s1_addr_r   <= base_r + row_addr_r + ADDR_W'(idx_r);
    end
    if (s1_move) begin
      out_addr_r <= s1_addr_r;
      out_data_r <= s1_filled_r ? rd_data_r : SPACE_CODE;
      out_last_r <= s1_last_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.vram_address = out_addr_r;
  assign out_chan.vram_data    = out_data_r;
  assign out_chan.last_of_row  = out_last_r;

endmodule

>>> hw/rtl/text_line_screen_writer_unit.sv
// Top level of the text line screen writer: front end, command queue and
// back end joined together. Depends on tlsw_pkg, tlsw_if, tlsw_front, tlsw_back.
//
// Ordinary characters are taken one per cycle and stored in a 40-entry line
// buffer; characters beyond the last column are dropped. A newline, or an end
// item while the row holds at least one character, writes the whole row out as
// 40 video memory writes at name table base + row * 40 + column (modulo 2^14),
// at most one per cycle from the single read port of the line buffer, with
// last_of_row set on the final one. While a row drains, the two-entry command
// queue still takes up to two further items; after that input waits until the
// drain ends. A newline then moves to the next row (wrapping after row 23) and
// refills the buffer with spaces at once. The name table base must be written
// over the always-ready cfg channel only while the block is idle (unchecked).
module text_line_screen_writer_unit (
  input  logic       clk,
  input  logic       rst_n,
  tlsw_in_if.sink    in_chan,
  tlsw_out_if.source out_chan,
  tlsw_cfg_if.sink   cfg_chan
);
  import tlsw_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  tlsw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tlsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg_chan  (cfg_chan),
    .out_chan  (out_chan)
  );

endmodule
